### rtl/core/rbsc_pkg.sv
// ----------------------------------------------------------------------------
// rbsc_pkg
// Types, widths and codes shared by the ROM bank slot cache.
// ----------------------------------------------------------------------------
package rbsc_pkg;

    localparam int BANK_W = 9;              // bank number width
    localparam int SLOT_W = 9;              // slot number width
    localparam int CFG_W  = 10;             // configuration register width
    localparam int CNT_W  = 10;             // holds a bank or slot count itself
    localparam int MAP_W  = SLOT_W + 1;     // valid bit and slot

    localparam int MAX_BANKS = 1 << BANK_W;
    localparam int MAX_SLOTS = 1 << SLOT_W;

    localparam logic [CFG_W-1:0] ROM_BANK_COUNT_RST = CFG_W'(MAX_BANKS);
    localparam logic [CFG_W-1:0] SLOT_COUNT_RST     = CFG_W'(128);

    typedef enum logic [1:0] {
        OP_SELECT = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_INIT   = 2'd2
    } opcode_t;

    typedef enum logic {
        CFG_ROM_BANK_COUNT = 1'b0,
        CFG_SLOT_COUNT     = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic              valid;
        logic [SLOT_W-1:0] slot;
    } map_entry_t;

endpackage

### rtl/core/rbsc_if.sv
// ----------------------------------------------------------------------------
// rbsc_if
// Request and response channels of the ROM bank slot cache.
// ----------------------------------------------------------------------------
interface rbsc_req_if
    import rbsc_pkg::*;
    ();
    logic              valid;
    logic              ready;
    logic [1:0]        opcode;
    logic [BANK_W-1:0] bank;

    modport source (output valid, output opcode, output bank, input ready);
    modport sink   (input valid, input opcode, input bank, output ready);
endinterface

interface rbsc_rsp_if
    import rbsc_pkg::*;
    ();
    logic              valid;
    logic              ready;
    logic [SLOT_W-1:0] slot;
    logic              mapped;
    logic              fetch_needed;
    logic              evicted_valid;
    logic [BANK_W-1:0] evicted_bank;
    logic              out_of_range;

    modport source (output valid, output slot, output mapped, output fetch_needed,
                    output evicted_valid, output evicted_bank, output out_of_range,
                    input ready);
    modport sink   (input valid, input slot, input mapped, input fetch_needed,
                    input evicted_valid, input evicted_bank, input out_of_range,
                    output ready);
endinterface

### rtl/core/rom_bank_slot_cache_top.sv
// Path from the accepting edge: a select or lookup passes CHECK then DONE, a select
// that evicts also VICTIM, EVICT1 and EVICT2; out of range or an unknown opcode goes
// straight to DONE; an init item rebuilds the table in SWEEP, one table entry written
// per cycle, then DONE. One item at a time: ready returns as the result is registered,
// and DONE holds while the output register is full; the state machine sequences the
// single map port and queue port. After reset SWEEP builds the table with ready low.
// ----------------------------------------------------------------------------
// rom_bank_slot_cache_top
// Maps ROM bank numbers onto buffer slots with FIFO eviction of loaded banks.
// ----------------------------------------------------------------------------
module rom_bank_slot_cache_top
    import rbsc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [CFG_W-1:0]  cfg_wdata,
    rbsc_req_if.sink          req,
    rbsc_rsp_if.source        rsp
);

    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_CHECK,
        ST_VICTIM,
        ST_EVICT1,
        ST_EVICT2,
        ST_DONE
    } state_t;

    state_t state_reg;

    logic [CFG_W-1:0]  rom_bank_count_reg;
    logic [CFG_W-1:0]  slot_count_reg;

    map_entry_t        map_mem [MAX_BANKS];
    logic [BANK_W-1:0] queue_mem [MAX_SLOTS];
    map_entry_t        map_rdata_reg;
    logic [BANK_W-1:0] q_rdata_reg;

    logic [SLOT_W-1:0] sweep_idx_reg;
    logic [CNT_W-1:0]  used_reg;
    logic [SLOT_W-1:0] count_reg;
    logic [SLOT_W-1:0] head_reg;
    logic              sweep_item_reg;

    logic [1:0]        op_reg;
    logic [BANK_W-1:0] bank_reg;
    logic [BANK_W-1:0] victim_reg;
    logic [SLOT_W-1:0] vslot_reg;

    logic [SLOT_W-1:0] res_slot_reg;
    logic              res_mapped_reg;
    logic              res_fetch_reg;
    logic              res_ev_valid_reg;
    logic [BANK_W-1:0] res_ev_bank_reg;
    logic              res_oor_reg;

    logic              out_valid_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic              mapped_reg;
    logic              fetch_reg;
    logic              ev_valid_reg;
    logic [BANK_W-1:0] ev_bank_reg;
    logic              oor_reg;

    logic [CNT_W-1:0]  eff_banks;
    logic [CNT_W-1:0]  eff_slots;
    logic [CNT_W-1:0]  used_calc;
    logic              req_oor;
    logic              can_evict;
    logic [SLOT_W-1:0] back_idx;
    logic              accept;

    logic              map_we;
    logic [BANK_W-1:0] map_waddr;
    map_entry_t        map_wdata;
    logic [BANK_W-1:0] map_raddr;
    logic              q_we;
    logic [SLOT_W-1:0] q_waddr;
    logic [BANK_W-1:0] q_wdata;

    // ------------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rom_bank_count_reg <= ROM_BANK_COUNT_RST;
            slot_count_reg     <= SLOT_COUNT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ROM_BANK_COUNT: rom_bank_count_reg <= cfg_wdata;
                CFG_SLOT_COUNT:     slot_count_reg     <= cfg_wdata;
                default:            ;
            endcase
        end
    end

    // Clamp the registers to their usable ranges
    always_comb
    begin
        if (rom_bank_count_reg == '0)
            eff_banks = CNT_W'(1);
        else if (rom_bank_count_reg > CNT_W'(MAX_BANKS))
            eff_banks = CNT_W'(MAX_BANKS);
        else
            eff_banks = rom_bank_count_reg;

        if (slot_count_reg < CNT_W'(2))
            eff_slots = CNT_W'(2);
        else if (slot_count_reg > CNT_W'(MAX_SLOTS))
            eff_slots = CNT_W'(MAX_SLOTS);
        else
            eff_slots = slot_count_reg;

        used_calc = (eff_banks < eff_slots) ? eff_banks : eff_slots;
    end

    assign accept    = req.valid && req.ready;
    assign req_oor   = {1'b0, req.bank} >= eff_banks;
    assign back_idx  = SLOT_W'(head_reg + count_reg - SLOT_W'(1));
    assign can_evict = (op_reg == OP_SELECT) && (bank_reg != '0)
                       && (eff_banks > ({1'b0, count_reg} + CNT_W'(1)))
                       && (count_reg != '0);

    // ------------------------------------------------------------------------
    // Memory port control
    // ------------------------------------------------------------------------
    always_comb
    begin
        map_we    = 1'b0;
        map_waddr = sweep_idx_reg;
        map_wdata = '0;
        q_we      = 1'b0;
        q_waddr   = sweep_idx_reg;
        q_wdata   = '0;
        map_raddr = (state_reg == ST_VICTIM) ? q_rdata_reg : req.bank;

        case (state_reg)
            ST_SWEEP:
            begin
                map_we = 1'b1;
                if ({1'b0, sweep_idx_reg} < used_reg)
                begin
                    map_wdata.valid = 1'b1;
                    map_wdata.slot  = sweep_idx_reg;
                end
                q_we = 1'b1;
                if (({1'b0, sweep_idx_reg} + CNT_W'(1)) < used_reg)
                    q_wdata = BANK_W'(sweep_idx_reg + SLOT_W'(1));
            end
            ST_EVICT1:
            begin
                // free the victim's map entry
                map_we    = 1'b1;
                map_waddr = victim_reg;
            end
            ST_EVICT2:
            begin
                map_we          = 1'b1;
                map_waddr       = bank_reg;
                map_wdata.valid = 1'b1;
                map_wdata.slot  = vslot_reg;
                q_we            = 1'b1;
                q_waddr         = SLOT_W'(head_reg - SLOT_W'(1));
                q_wdata         = bank_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (map_we)
            map_mem[map_waddr] <= map_wdata;
        map_rdata_reg <= map_mem[map_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (q_we)
            queue_mem[q_waddr] <= q_wdata;
        q_rdata_reg <= queue_mem[back_idx];
    end

    // ------------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_SWEEP;
            sweep_idx_reg  <= '0;
            used_reg       <= CNT_W'(128);
            count_reg      <= SLOT_W'(127);
            head_reg       <= '0;
            sweep_item_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            // the finishing state reloads the output register itself
            if (rsp.valid && rsp.ready && (state_reg != ST_DONE))
                out_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        op_reg           <= req.opcode;
                        bank_reg         <= req.bank;
                        res_slot_reg     <= '0;
                        res_mapped_reg   <= 1'b0;
                        res_fetch_reg    <= 1'b0;
                        res_ev_valid_reg <= 1'b0;
                        res_ev_bank_reg  <= '0;
                        res_oor_reg      <= 1'b0;
                        case (req.opcode)
                            OP_INIT:
                            begin
                                used_reg       <= used_calc;
                                count_reg      <= SLOT_W'(used_calc - CNT_W'(1));
                                head_reg       <= '0;
                                sweep_idx_reg  <= '0;
                                sweep_item_reg <= 1'b1;
                                state_reg      <= ST_SWEEP;
                            end
                            OP_SELECT, OP_LOOKUP:
                            begin
                                if (req_oor)
                                begin
                                    res_oor_reg <= 1'b1;
                                    state_reg   <= ST_DONE;
                                end
                                else
                                    state_reg <= ST_CHECK;
                            end
                            default: state_reg <= ST_DONE;
                        endcase
                    end
                end
                ST_SWEEP:
                begin
                    sweep_idx_reg <= sweep_idx_reg + SLOT_W'(1);
                    if (sweep_idx_reg == '1)
                        state_reg <= sweep_item_reg ? ST_DONE : ST_IDLE;
                end
                ST_CHECK:
                begin
                    if (map_rdata_reg.valid)
                    begin
                        res_mapped_reg <= 1'b1;
                        res_slot_reg   <= map_rdata_reg.slot;
                        state_reg      <= ST_DONE;
                    end
                    else if (can_evict)
                        state_reg <= ST_VICTIM;
                    else
                        state_reg <= ST_DONE;
                end
                ST_VICTIM:
                begin
                    victim_reg <= q_rdata_reg;
                    state_reg  <= ST_EVICT1;
                end
                ST_EVICT1:
                begin
                    vslot_reg <= map_rdata_reg.slot;
                    state_reg <= ST_EVICT2;
                end
                ST_EVICT2:
                begin
                    // pop the back, push the new bank on the front
                    head_reg         <= SLOT_W'(head_reg - SLOT_W'(1));
                    res_slot_reg     <= vslot_reg;
                    res_fetch_reg    <= 1'b1;
                    res_ev_valid_reg <= 1'b1;
                    res_ev_bank_reg  <= victim_reg;
                    state_reg        <= ST_DONE;
                end
                ST_DONE:
                begin
                    // hold until the output register is free
                    if (!out_valid_reg || rsp.ready)
                    begin
                        out_valid_reg  <= 1'b1;
                        slot_reg       <= res_slot_reg;
                        mapped_reg     <= res_mapped_reg;
                        fetch_reg      <= res_fetch_reg;
                        ev_valid_reg   <= res_ev_valid_reg;
                        ev_bank_reg    <= res_ev_bank_reg;
                        oor_reg        <= res_oor_reg;
                        sweep_item_reg <= 1'b0;
                        state_reg      <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign req.ready         = (state_reg == ST_IDLE);
    assign rsp.valid         = out_valid_reg;
    assign rsp.slot          = slot_reg;
    assign rsp.mapped        = mapped_reg;
    assign rsp.fetch_needed  = fetch_reg;
    assign rsp.evicted_valid = ev_valid_reg;
    assign rsp.evicted_bank  = ev_bank_reg;
    assign rsp.out_of_range  = oor_reg;

endmodule

### rtl/core/rbsc_checker.sv
// ----------------------------------------------------------------------------
// rbsc_checker
// Port-level checks on the ROM bank slot cache, bound to the top level.
// ----------------------------------------------------------------------------
module rbsc_checker
    import rbsc_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_ready,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input logic [SLOT_W-1:0] rsp_slot,
    input logic              rsp_mapped,
    input logic              rsp_fetch_needed,
    input logic              rsp_evicted_valid,
    input logic [BANK_W-1:0] rsp_evicted_bank,
    input logic              rsp_out_of_range
);

    // a stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_slot)
            && $stable(rsp_evicted_bank) && $stable(rsp_fetch_needed))
        else $error("response changed while stalled");

    // one item at a time: ready drops after a transfer
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while an item is in progress");

    a_oor_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_out_of_range |-> rsp_slot == '0 && !rsp_mapped
            && !rsp_fetch_needed && !rsp_evicted_valid && rsp_evicted_bank == '0)
        else $error("out of range result carries data");

    a_fetch_evict: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_fetch_needed || rsp_evicted_valid) |->
            rsp_fetch_needed && rsp_evicted_valid && !rsp_mapped)
        else $error("fetch and eviction flags disagree");

    a_evict_bank_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_evicted_valid |-> rsp_evicted_bank == '0)
        else $error("evicted bank set without eviction");

endmodule

bind rom_bank_slot_cache_top rbsc_checker u_rbsc_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .req_valid         (req.valid),
    .req_ready         (req.ready),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_slot          (rsp.slot),
    .rsp_mapped        (rsp.mapped),
    .rsp_fetch_needed  (rsp.fetch_needed),
    .rsp_evicted_valid (rsp.evicted_valid),
    .rsp_evicted_bank  (rsp.evicted_bank),
    .rsp_out_of_range  (rsp.out_of_range)
);

### tb/slot_map_checker.sv
// ----------------------------------------------------------------------------
// slot_map_checker
// Watches the request, response and configuration ports of the ROM bank slot
// cache. Keeps its own bank-to-slot map and load-order queue, works out the
// answer to every accepted request and compares each response transfer with
// the oldest answer still owed.
// ----------------------------------------------------------------------------
module slot_map_checker
    import rbsc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_wdata,
    rbsc_req_if              req,
    rbsc_rsp_if              rsp,
    output int               mismatches,
    output int               outstanding
);

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              mapped;
        logic              fetch_needed;
        logic              evicted_valid;
        logic [BANK_W-1:0] evicted_bank;
        logic              out_of_range;
    } slot_answer_t;

    logic [CFG_W-1:0]  bank_count_reg;
    logic [CFG_W-1:0]  slot_count_reg;
    map_entry_t        slot_map [MAX_BANKS];
    logic [BANK_W-1:0] load_order [MAX_SLOTS];
    logic [SLOT_W-1:0] order_head;
    int                order_count;

    slot_answer_t      owed_answers [$];
    int                err_total  = 0;
    int                open_count = 0;

    assign mismatches  = err_total;
    assign outstanding = open_count;

    function automatic int bank_limit();
        int n;
        n = int'(bank_count_reg);
        if (n < 1)
            n = 1;
        if (n > MAX_BANKS)
            n = MAX_BANKS;
        return n;
    endfunction

    function automatic int slot_limit();
        int n;
        n = int'(slot_count_reg);
        if (n < 2)
            n = 2;
        if (n > MAX_SLOTS)
            n = MAX_SLOTS;
        return n;
    endfunction

    // Identity map for the banks in use, queue holds banks 1 .. used-1.
    function automatic void rebuild_map();
        int used;
        used = (bank_limit() < slot_limit()) ? bank_limit() : slot_limit();
        for (int i = 0; i < MAX_BANKS; i++)
            slot_map[i] = '0;
        for (int i = 0; i < MAX_SLOTS; i++)
            load_order[i] = '0;
        slot_map[0].valid = 1'b1;
        for (int i = 1; i < used; i++)
        begin
            slot_map[i]       = {1'b1, SLOT_W'(i)};
            load_order[i - 1] = BANK_W'(i);
        end
        order_head  = '0;
        order_count = used - 1;
    endfunction

    function automatic slot_answer_t predict_access(logic [1:0] op, logic [BANK_W-1:0] bank);
        slot_answer_t      ans;
        int                back;
        logic [BANK_W-1:0] victim;
        logic [SLOT_W-1:0] freed;
        ans = '0;
        if (op == OP_INIT)
        begin
            rebuild_map();
        end
        else if (op == OP_SELECT || op == OP_LOOKUP)
        begin
            if (int'(bank) >= bank_limit())
            begin
                ans.out_of_range = 1'b1;
            end
            else if (slot_map[bank].valid)
            begin
                ans.mapped = 1'b1;
                ans.slot   = slot_map[bank].slot;
            end
            else if (op == OP_SELECT && bank != '0 && bank_limit() > order_count + 1
                     && order_count != 0)
            begin
                // evict from the back, push the newcomer onto the front
                back = int'(order_head) + order_count - 1;
                if (back >= MAX_SLOTS)
                    back -= MAX_SLOTS;
                victim           = load_order[back];
                freed            = slot_map[victim].slot;
                slot_map[victim] = '0;
                slot_map[bank]   = {1'b1, freed};
                order_head       = order_head - 1'b1;
                load_order[order_head] = bank;
                ans.slot          = freed;
                ans.fetch_needed  = 1'b1;
                ans.evicted_valid = 1'b1;
                ans.evicted_bank  = victim;
            end
        end
        return ans;
    endfunction

    function automatic void check_field(string name, logic [9:0] want, logic [9:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_total++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        slot_answer_t want;
        if (!rst_n)
        begin
            bank_count_reg = ROM_BANK_COUNT_RST;
            slot_count_reg = SLOT_COUNT_RST;
            rebuild_map();
            owed_answers.delete();
            open_count <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_ROM_BANK_COUNT)
                    bank_count_reg = cfg_wdata;
                else
                    slot_count_reg = cfg_wdata;
            end
            if (rsp.valid && rsp.ready)
            begin
                if (owed_answers.size() == 0)
                begin
                    $error("result transfer with nothing owed: slot %0d", rsp.slot);
                    err_total++;
                end
                else
                begin
                    want = owed_answers.pop_front();
                    check_field("slot", 10'(want.slot), 10'(rsp.slot));
                    check_field("mapped", 10'(want.mapped), 10'(rsp.mapped));
                    check_field("fetch_needed", 10'(want.fetch_needed), 10'(rsp.fetch_needed));
                    check_field("evicted_valid", 10'(want.evicted_valid),
                                10'(rsp.evicted_valid));
                    check_field("evicted_bank", 10'(want.evicted_bank), 10'(rsp.evicted_bank));
                    check_field("out_of_range", 10'(want.out_of_range), 10'(rsp.out_of_range));
                end
            end
            if (req.valid && req.ready)
            begin
                want         = predict_access(req.opcode, req.bank);
                owed_answers = {owed_answers, want};
            end
            open_count <= owed_answers.size();
        end
    end

endmodule

### tb/rom_bank_slot_cache_top_tb.sv
// ----------------------------------------------------------------------------
// rom_bank_slot_cache_top_tb
// Drives select, lookup, init and unknown requests into the ROM bank slot
// cache over a series of bank and slot count settings, with random gaps on
// both channels and long response hold-offs. The checker beside the block
// predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module rom_bank_slot_cache_top_tb;
    import rbsc_pkg::*;

    localparam logic [1:0] OP_UNKNOWN   = 2'd3;
    localparam int         CYCLE_LIMIT  = 3000000;
    localparam int         DRAIN_CYCLES = 20;
    localparam int         PHASES       = 15;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic             cfg_index;
    logic [CFG_W-1:0] cfg_wdata;

    int mismatches;
    int outstanding;
    int cycle_count = 0;
    int bank_span;
    bit send_burst;

    logic [BANK_W-1:0] recent_banks [$];

    int phase_banks [PHASES] = '{4, 16, 64, 1, 512, 0, 1023, 512, 32, 64, 8, 256, 2, 128, 512};
    int phase_slots [PHASES] = '{1023, 4, 0, 2, 2, 3, 512, 511, 8, 8, 8, 1, 5, 16, 128};
    bit phase_init  [PHASES] = '{1, 1, 1, 1, 0, 1, 1, 1, 1, 0, 0, 1, 1, 1, 1};
    int phase_items [PHASES] = '{60, 120, 80, 40, 60, 40, 80, 100, 80, 80, 60, 80, 40, 120, 80};

    rbsc_req_if req_ch ();
    rbsc_rsp_if rsp_ch ();

    rom_bank_slot_cache_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    slot_map_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Valid is only lowered when a gap follows, so back-to-back transfers keep it high.
    task automatic send_item(logic [1:0] op, logic [BANK_W-1:0] bank);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid  <= 1'b1;
        req_ch.opcode <= op;
        req_ch.bank   <= bank;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic set_config(int banks, int slots);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_ROM_BANK_COUNT;
        cfg_wdata <= CFG_W'(banks);
        @(posedge clk);
        cfg_index <= CFG_SLOT_COUNT;
        cfg_wdata <= CFG_W'(slots);
        @(posedge clk);
        cfg_we    <= 1'b0;
        bank_span = (banks < 1) ? 1 : (banks > MAX_BANKS) ? MAX_BANKS : banks;
    endtask

    task automatic send_random(int n);
        int                pick;
        logic [1:0]        op;
        logic [BANK_W-1:0] bank;
        for (int i = 0; i < n; i++)
        begin
            if (i % 40 == 0)
                send_burst = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 60)
                op = OP_SELECT;
            else if (pick < 87)
                op = OP_LOOKUP;
            else if (pick < 94)
                op = OP_UNKNOWN;
            else
                op = OP_INIT;
            // mostly banks in range, with revisits so hits follow evictions
            pick = $urandom_range(0, 99);
            if (pick < 8)
                bank = BANK_W'($urandom_range(0, MAX_BANKS - 1));
            else if (pick < 13)
                bank = '0;
            else if (pick < 40 && recent_banks.size() > 0)
                bank = recent_banks[$urandom_range(0, recent_banks.size() - 1)];
            else
                bank = BANK_W'($urandom_range(0, bank_span - 1));
            if (op == OP_SELECT)
            begin
                recent_banks = {recent_banks, bank};
                if (recent_banks.size() > 8)
                    void'(recent_banks.pop_front());
            end
            send_item(op, bank);
        end
    endtask

    initial
    begin : result_sink
        int stall_left;
        int hold_left;
        int taken;
        bit sink_burst;
        stall_left = 0;
        hold_left  = 0;
        taken      = 0;
        sink_burst = 1'b0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                taken++;
                if (taken % 50 == 0)
                    sink_burst = ($urandom_range(0, 3) == 0);
                // hold off long enough for the request side to back up
                if (taken == 150 || taken == 700)
                    hold_left = 300;
                stall_left = sink_burst ? 0 : $urandom_range(0, 4);
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    initial
    begin : stimulus
        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_index     <= CFG_ROM_BANK_COUNT;
        cfg_wdata     <= '0;
        req_ch.valid  <= 1'b0;
        req_ch.opcode <= OP_SELECT;
        req_ch.bank   <= '0;
        send_burst = 1'b0;
        bank_span  = MAX_BANKS;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // reset table: 512 banks over 128 slots
        send_item(OP_SELECT, 9'd0);
        send_item(OP_LOOKUP, 9'd0);
        send_item(OP_SELECT, 9'd1);
        send_item(OP_SELECT, 9'd127);
        send_item(OP_LOOKUP, 9'd128);
        send_item(OP_SELECT, 9'd128);
        send_item(OP_SELECT, 9'd511);
        send_item(OP_LOOKUP, 9'd511);
        send_item(OP_SELECT, 9'd127);
        send_item(OP_SELECT, 9'd128);
        send_item(OP_UNKNOWN, 9'd511);
        send_item(OP_UNKNOWN, 9'd0);
        send_item(OP_LOOKUP, 9'd127);
        send_item(OP_INIT, 9'd511);
        send_item(OP_LOOKUP, 9'd128);
        send_item(OP_SELECT, 9'd0);

        // every bank fits; out of range just above the bank count
        set_config(4, 1023);
        send_item(OP_INIT, 9'd0);
        send_item(OP_SELECT, 9'd4);
        send_item(OP_LOOKUP, 9'd511);
        send_item(OP_SELECT, 9'd3);

        // single bank, then widen the bank count without rebuilding: empty queue
        set_config(1, 2);
        send_item(OP_INIT, 9'd0);
        send_item(OP_SELECT, 9'd1);
        send_item(OP_SELECT, 9'd0);
        set_config(512, 2);
        send_item(OP_SELECT, 9'd5);
        send_item(OP_LOOKUP, 9'd5);

        for (int p = 0; p < PHASES; p++)
        begin
            set_config(phase_banks[p], phase_slots[p]);
            recent_banks.delete();
            if (phase_init[p])
                send_item(OP_INIT, BANK_W'($urandom_range(0, MAX_BANKS - 1)));
            send_random(phase_items[p]);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### filelist.f
rtl/core/rbsc_pkg.sv
rtl/core/rbsc_if.sv
rtl/core/rom_bank_slot_cache_top.sv
rtl/core/rbsc_checker.sv
tb/slot_map_checker.sv
tb/rom_bank_slot_cache_top_tb.sv
